/* src/ehpp_pkg.sv */
// Shared types and constants for the EEG headset packet parser.
package ehpp_pkg;

    localparam logic [7:0] SYNC_BYTE       = 8'hAA;
    localparam logic [7:0] QUALITY_DEFAULT = 8'd200;

    // Strobes from the frame control to the payload decoder.
    typedef struct packed {
        logic clear;   // start of a new payload: load the defaults
        logic step;    // decode the current payload byte
        logic commit;  // checksum matched with a raw sample pending
    } t_dec_ctrl;

    // Decoded values of the packet in flight and the committed raw sample.
    typedef struct packed {
        logic [7:0]  quality;
        logic [7:0]  attention;
        logic [7:0]  meditation;
        logic [15:0] raw;
        logic [5:0]  raw_count;
        logic        quality_seen;
        logic [15:0] committed_raw;
    } t_dec_vals;

endpackage

/* src/ehpp_if.sv */
// Ready/valid channel interfaces for serial bytes and packet results.
interface ehpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ehpp_out_if;
    logic               valid;
    logic               ready;
    logic               checksum_ok;
    logic [7:0]         payload_length;
    logic [7:0]         signal_quality;
    logic [7:0]         attention_level;
    logic [7:0]         meditation_level;
    logic signed [15:0] raw_sample;
    logic [5:0]         raw_count;
    logic               quality_seen;

    modport source (output valid, output checksum_ok, output payload_length,
                    output signal_quality, output attention_level,
                    output meditation_level, output raw_sample, output raw_count,
                    output quality_seen, input ready);
    modport sink   (input valid, input checksum_ok, input payload_length,
                    input signal_quality, input attention_level,
                    input meditation_level, input raw_sample, input raw_count,
                    input quality_seen, output ready);
endinterface

/* src/ehpp_decoder.sv */
// Payload code decoder holding the pending values and the committed raw sample.
module ehpp_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ehpp_pkg::t_dec_ctrl i_ctrl,
    input  logic [7:0]         i_data,
    output ehpp_pkg::t_dec_vals o_vals
);
    import ehpp_pkg::*;

    localparam logic [2:0] DP_CODE   = 3'd0;
    localparam logic [2:0] DP_QUAL   = 3'd1;
    localparam logic [2:0] DP_ATT    = 3'd2;
    localparam logic [2:0] DP_MED    = 3'd3;
    localparam logic [2:0] DP_RAWLEN = 3'd4;
    localparam logic [2:0] DP_RAWHI  = 3'd5;
    localparam logic [2:0] DP_RAWLO  = 3'd6;
    localparam logic [2:0] DP_SKIP   = 3'd7;

    localparam logic [7:0] CODE_QUALITY    = 8'h02;
    localparam logic [7:0] CODE_ATTENTION  = 8'h04;
    localparam logic [7:0] CODE_MEDITATION = 8'h05;
    localparam logic [7:0] CODE_RAW        = 8'h80;
    localparam logic [7:0] CODE_SKIP       = 8'h83;
    localparam logic [4:0] SKIP_BYTES      = 5'd25;
    localparam logic [5:0] RAW_COUNT_MAX   = 6'd63;

    logic [2:0]  r_phase, n_phase;
    logic [4:0]  r_skip, n_skip;
    logic [7:0]  r_raw_high, n_raw_high;
    t_dec_vals   r_vals, n_vals;

    always_comb begin
        n_phase    = r_phase;
        n_skip     = r_skip;
        n_raw_high = r_raw_high;
        n_vals     = r_vals;
        if (i_ctrl.clear) begin
            n_phase             = DP_CODE;
            n_skip              = '0;
            n_raw_high          = '0;
            n_vals.quality      = QUALITY_DEFAULT;
            n_vals.attention    = '0;
            n_vals.meditation   = '0;
            n_vals.raw          = '0;
            n_vals.raw_count    = '0;
            n_vals.quality_seen = 1'b0;
        end else if (i_ctrl.step) begin
            case (r_phase)
                DP_CODE: begin
                    if (i_data == CODE_QUALITY) begin
                        n_phase = DP_QUAL;
                    end else if (i_data == CODE_ATTENTION) begin
                        n_phase = DP_ATT;
                    end else if (i_data == CODE_MEDITATION) begin
                        n_phase = DP_MED;
                    end else if (i_data == CODE_RAW) begin
                        n_phase = DP_RAWLEN;
                    end else if (i_data == CODE_SKIP) begin
                        n_skip  = SKIP_BYTES;
                        n_phase = DP_SKIP;
                    end
                end
                DP_QUAL: begin
                    n_vals.quality      = i_data;
                    n_vals.quality_seen = 1'b1;
                    n_phase             = DP_CODE;
                end
                DP_ATT: begin
                    n_vals.attention = i_data;
                    n_phase          = DP_CODE;
                end
                DP_MED: begin
                    n_vals.meditation = i_data;
                    n_phase           = DP_CODE;
                end
                DP_RAWLEN: begin
                    n_phase = DP_RAWHI;
                end
                DP_RAWHI: begin
                    n_raw_high = i_data;
                    n_phase    = DP_RAWLO;
                end
                DP_RAWLO: begin
                    n_vals.raw = {r_raw_high, i_data};
                    if (r_vals.raw_count != RAW_COUNT_MAX) begin
                        n_vals.raw_count = r_vals.raw_count + 6'd1;
                    end
                    n_phase = DP_CODE;
                end
                default: begin
                    if (r_skip != 5'd0) begin
                        n_skip = r_skip - 5'd1;
                    end
                    if (r_skip <= 5'd1) begin
                        n_phase = DP_CODE;
                    end
                end
            endcase
        end
        if (i_ctrl.commit) begin
            n_vals.committed_raw = r_vals.raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase                    <= DP_CODE;
            r_skip                     <= '0;
            r_raw_high                 <= '0;
            r_vals.quality             <= QUALITY_DEFAULT;
            r_vals.attention           <= '0;
            r_vals.meditation          <= '0;
            r_vals.raw                 <= '0;
            r_vals.raw_count           <= '0;
            r_vals.quality_seen        <= 1'b0;
            r_vals.committed_raw       <= '0;
        end else begin
            r_phase    <= n_phase;
            r_skip     <= n_skip;
            r_raw_high <= n_raw_high;
            r_vals     <= n_vals;
        end
    end

    assign o_vals = r_vals;

endmodule

/* src/eeg_headset_packet_parser.sv */
// Top level of the EEG headset serial packet parser.
//
//   Channel  Direction  Payload                                     Moves
//   i_rx     in         rx_byte                                     one byte per request
//   o_res    out        checksum_ok, payload_length, signal_quality, one result per packet
//                       attention_level, meditation_level,
//                       raw_sample, raw_count, quality_seen
//
// One byte is taken every clock cycle while no checksum byte is stalled. A byte
// passes an input register and is decoded in the following cycle; a checksum byte
// loads its result into the output register once that register is free.
// Synchronous active-low reset returns the parser to the hunt for the first sync
// byte. A waiting result stalls the input only when the next checksum byte is
// ready to be processed; all other bytes keep flowing while the result sits in
// the output register.
module eeg_headset_packet_parser #(
    parameter int MAX_PAYLOAD = 169
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ehpp_in_if.sink         i_rx,
    ehpp_out_if.source      o_res
);
    import ehpp_pkg::*;

    localparam logic [2:0] FP_HUNT1   = 3'd0;
    localparam logic [2:0] FP_HUNT2   = 3'd1;
    localparam logic [2:0] FP_LEN     = 3'd2;
    localparam logic [2:0] FP_PAYLOAD = 3'd3;
    localparam logic [2:0] FP_CHECK   = 3'd4;

    localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Frame tracking state.
    logic [2:0] r_frame_phase, n_frame_phase;
    logic [7:0] r_frame_length, n_frame_length;
    logic [7:0] r_bytes_seen, n_bytes_seen;
    logic [7:0] r_sum, n_sum;

    // Result register.
    logic               r_out_valid;
    logic               r_ok;
    logic [7:0]         r_len;
    logic [7:0]         r_quality;
    logic [7:0]         r_attention;
    logic [7:0]         r_meditation;
    logic [15:0]        r_raw;
    logic [5:0]         r_raw_count;
    logic               r_quality_seen;

    t_dec_ctrl  dec_ctrl;
    t_dec_vals  dec_vals;

    logic is_check;
    logic out_free;
    logic advance;
    logic in_ready;
    logic sum_ok;

    assign is_check = (r_frame_phase == FP_CHECK);
    assign out_free = !r_out_valid || o_res.ready;
    // The byte in the input register moves on unless it is a checksum byte
    // whose result has nowhere to go yet.
    assign advance  = r_in_valid && (!is_check || out_free);
    assign in_ready = !r_in_valid || advance;
    assign sum_ok   = (r_in_byte == ~r_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // Frame sequencing: sync, sync, length, payload bytes, checksum.
    always_comb begin
        n_frame_phase  = r_frame_phase;
        n_frame_length = r_frame_length;
        n_bytes_seen   = r_bytes_seen;
        n_sum          = r_sum;
        dec_ctrl       = '0;
        if (advance) begin
            case (r_frame_phase)
                FP_HUNT1: begin
                    if (r_in_byte == SYNC_BYTE) begin
                        n_frame_phase = FP_HUNT2;
                    end
                end
                FP_HUNT2: begin
                    n_frame_phase = (r_in_byte == SYNC_BYTE) ? FP_LEN : FP_HUNT1;
                end
                FP_LEN: begin
                    if (r_in_byte > MaxLen) begin
                        n_frame_phase = FP_HUNT1;
                    end else begin
                        n_frame_length = r_in_byte;
                        n_bytes_seen   = '0;
                        n_sum          = '0;
                        dec_ctrl.clear = 1'b1;
                        n_frame_phase  = (r_in_byte == 8'd0) ? FP_CHECK : FP_PAYLOAD;
                    end
                end
                FP_PAYLOAD: begin
                    n_sum         = r_sum + r_in_byte;
                    dec_ctrl.step = 1'b1;
                    n_bytes_seen  = r_bytes_seen + 8'd1;
                    if (n_bytes_seen >= r_frame_length) begin
                        n_frame_phase = FP_CHECK;
                    end
                end
                FP_CHECK: begin
                    dec_ctrl.commit = sum_ok && (dec_vals.raw_count != 6'd0);
                    n_frame_phase   = FP_HUNT1;
                end
                default: begin
                    n_frame_phase = FP_HUNT1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_phase  <= FP_HUNT1;
            r_frame_length <= '0;
            r_bytes_seen   <= '0;
            r_sum          <= '0;
        end else begin
            r_frame_phase  <= n_frame_phase;
            r_frame_length <= n_frame_length;
            r_bytes_seen   <= n_bytes_seen;
            r_sum          <= n_sum;
        end
    end

    ehpp_decoder u_decoder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (dec_ctrl),
        .i_data  (r_in_byte),
        .o_vals  (dec_vals)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && is_check) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // On a mismatch the decoded fields read as zero and the raw sample shows
    // the value committed by an earlier packet.
    always_ff @(posedge i_clk) begin
        if (advance && is_check) begin
            r_ok           <= sum_ok;
            r_len          <= r_frame_length;
            r_quality      <= sum_ok ? dec_vals.quality : 8'd0;
            r_attention    <= sum_ok ? dec_vals.attention : 8'd0;
            r_meditation   <= sum_ok ? dec_vals.meditation : 8'd0;
            r_raw          <= dec_ctrl.commit ? dec_vals.raw : dec_vals.committed_raw;
            r_raw_count    <= sum_ok ? dec_vals.raw_count : 6'd0;
            r_quality_seen <= sum_ok && dec_vals.quality_seen;
        end
    end

    assign i_rx.ready             = in_ready;
    assign o_res.valid            = r_out_valid;
    assign o_res.checksum_ok      = r_ok;
    assign o_res.payload_length   = r_len;
    assign o_res.signal_quality   = r_quality;
    assign o_res.attention_level  = r_attention;
    assign o_res.meditation_level = r_meditation;
    assign o_res.raw_sample       = $signed(r_raw);
    assign o_res.raw_count        = r_raw_count;
    assign o_res.quality_seen     = r_quality_seen;

endmodule

/* src/ehpp_checker.sv */
// Port-level assertions for the packet parser and the bind that attaches them.
module ehpp_checker #(
    parameter int MAX_PAYLOAD = 169
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_checksum_ok,
    input logic [7:0]  i_payload_length,
    input logic [7:0]  i_signal_quality,
    input logic [7:0]  i_attention_level,
    input logic [7:0]  i_meditation_level,
    input logic [15:0] i_raw_sample,
    input logic [5:0]  i_raw_count,
    input logic        i_quality_seen
);
    import ehpp_pkg::*;

    localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_payload_length) &&
            $stable(i_raw_sample) && $stable(i_checksum_ok))
        else $error("result changed while stalled");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_checksum_ok |-> i_signal_quality == 8'd0 &&
            i_attention_level == 8'd0 && i_meditation_level == 8'd0 &&
            i_raw_count == 6'd0 && !i_quality_seen)
        else $error("failed packet shows decoded values");

    a_quality_default: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_checksum_ok && !i_quality_seen |->
            i_signal_quality == QUALITY_DEFAULT)
        else $error("missing quality does not read as the default");

    a_length_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_payload_length <= MaxLen)
        else $error("result for an oversize frame");

endmodule

bind eeg_headset_packet_parser ehpp_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_res.valid),
    .i_out_ready        (o_res.ready),
    .i_checksum_ok      (o_res.checksum_ok),
    .i_payload_length   (o_res.payload_length),
    .i_signal_quality   (o_res.signal_quality),
    .i_attention_level  (o_res.attention_level),
    .i_meditation_level (o_res.meditation_level),
    .i_raw_sample       (o_res.raw_sample),
    .i_raw_count        (o_res.raw_count),
    .i_quality_seen     (o_res.quality_seen)
);
